FILE: rtl/dik_pkg.sv
// Package: widths, tower count and register indices for the delta inverse kinematics block.
package dik_pkg;

    localparam int unsigned COORD_WIDTH = 20;
    localparam int unsigned IN_W        = 20;
    localparam int unsigned HEIGHT_W    = 23;
    localparam int unsigned NUM_TOWERS  = 3;

    localparam logic [2:0] REG_A_POS = 3'd0;
    localparam logic [2:0] REG_A_LEN = 3'd1;
    localparam logic [2:0] REG_B_POS = 3'd2;
    localparam logic [2:0] REG_B_LEN = 3'd3;
    localparam logic [2:0] REG_C_POS = 3'd4;
    localparam logic [2:0] REG_C_LEN = 3'd5;

endpackage

FILE: rtl/dik_isqrt.sv
// Pipelined integer square root, two result bits resolved per stage.
module dik_isqrt #(
    parameter int unsigned IN_W  = 48,
    parameter int unsigned SIDE_W = 1
) (
    input  logic                  i_clk,
    input  logic [IN_W-1:0]       i_rad,
    input  logic [SIDE_W-1:0]     i_side,
    output logic [(IN_W+1)/2-1:0] o_root,
    output logic [SIDE_W-1:0]     o_side
);

    localparam int unsigned OUT_W  = (IN_W + 1) / 2;
    localparam int unsigned RAD_W  = 2 * OUT_W;
    localparam int unsigned STEP_N = 2;
    localparam int unsigned STAGES = (OUT_W + STEP_N - 1) / STEP_N;
    localparam int unsigned REM_W  = OUT_W + 2;

    logic [RAD_W-1:0]  r_rad  [STAGES+1];
    logic [OUT_W-1:0]  r_root [STAGES+1];
    logic [REM_W-1:0]  r_rem  [STAGES+1];
    logic [SIDE_W-1:0] r_side [STAGES+1];

    always_comb begin
        r_rad[0]  = RAD_W'(i_rad);
        r_root[0] = '0;
        r_rem[0]  = '0;
        r_side[0] = i_side;
    end

    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic [RAD_W-1:0]  n_rad;
        logic [OUT_W-1:0]  n_root;
        logic [REM_W-1:0]  n_rem;

        always_comb begin
            logic [REM_W+1:0] trial;
            logic [REM_W+1:0] rem_sh;
            n_rad  = r_rad[s];
            n_root = r_root[s];
            n_rem  = r_rem[s];
            for (int k = 0; k < STEP_N; k++) begin
                if (s * STEP_N + k < OUT_W) begin
                    rem_sh = {n_rem, n_rad[RAD_W-1 -: 2]};
                    trial  = {n_root, 2'b01};
                    n_rad  = {n_rad[RAD_W-3:0], 2'b00};
                    if (rem_sh >= trial) begin
                        n_rem  = REM_W'(rem_sh - trial);
                        n_root = {n_root[OUT_W-2:0], 1'b1};
                    end else begin
                        n_rem  = REM_W'(rem_sh);
                        n_root = {n_root[OUT_W-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_rad[s+1]  <= n_rad;
            r_root[s+1] <= n_root;
            r_rem[s+1]  <= n_rem;
            r_side[s+1] <= r_side[s];
        end
    end

    assign o_root = r_root[STAGES];
    assign o_side = r_side[STAGES];

endmodule

FILE: rtl/dik_tower.sv
// One tower lane: planar distance, arm rise and carriage height.
module dik_tower #(
    parameter int unsigned COORD_WIDTH = dik_pkg::COORD_WIDTH
) (
    input  logic                            i_clk,
    input  logic signed [COORD_WIDTH-1:0]   i_tx,
    input  logic signed [COORD_WIDTH-1:0]   i_ty,
    input  logic        [COORD_WIDTH-1:0]   i_arm,
    input  logic signed [COORD_WIDTH-1:0]   i_hoff,
    input  logic signed [COORD_WIDTH-1:0]   i_voff,
    input  logic signed [dik_pkg::IN_W-1:0] i_hx,
    input  logic signed [dik_pkg::IN_W-1:0] i_hy,
    input  logic signed [dik_pkg::IN_W-1:0] i_hz,
    output logic signed [dik_pkg::HEIGHT_W-1:0] o_height,
    output logic                            o_unreach
);

    localparam int unsigned IW   = dik_pkg::IN_W;
    localparam int unsigned HW   = dik_pkg::HEIGHT_W;
    localparam int unsigned MW   = (COORD_WIDTH > IW) ? COORD_WIDTH : IW;
    localparam int unsigned DW   = MW + 1;
    localparam int unsigned SQW  = 2 * DW + 1;
    localparam int unsigned RW   = (SQW + 1) / 2;
    localparam int unsigned DDW  = RW + 1;
    localparam int unsigned PW   = 2 * DDW;
    localparam int unsigned ZW   = MW + 1;
    localparam int unsigned HSW  = PW + 2;
    localparam int unsigned SIDE_A = ZW + COORD_WIDTH * 2;
    localparam int unsigned SIDE_B = ZW + 1;

    // stage 1: differences
    logic signed [DW-1:0] r_dx, r_dy;
    logic [SIDE_A-1:0] r_s1;
    always_ff @(posedge i_clk) begin
        r_dx <= DW'(signed'(i_hx)) - DW'(i_tx);
        r_dy <= DW'(signed'(i_hy)) - DW'(i_ty);
        r_s1 <= {ZW'(signed'(i_hz)) + ZW'(i_voff), i_arm, i_hoff};
    end

    // stage 2: squares
    logic [2*DW-1:0] r_sx, r_sy;
    logic [SIDE_A-1:0] r_s2;
    always_ff @(posedge i_clk) begin
        r_sx <= (2*DW)'(r_dx * r_dx);
        r_sy <= (2*DW)'(r_dy * r_dy);
        r_s2 <= r_s1;
    end

    // stage 3: sum
    logic [SQW-1:0] r_sum;
    logic [SIDE_A-1:0] r_s3;
    always_ff @(posedge i_clk) begin
        r_sum <= SQW'(r_sx) + SQW'(r_sy);
        r_s3  <= r_s2;
    end

    logic [RW-1:0]     plane_dist;
    logic [SIDE_A-1:0] s4;
    dik_isqrt #(.IN_W(SQW), .SIDE_W(SIDE_A)) u_dist (
        .i_clk (i_clk),
        .i_rad (r_sum),
        .i_side(r_s3),
        .o_root(plane_dist),
        .o_side(s4)
    );

    logic signed [ZW-1:0]          s4_z;
    logic        [COORD_WIDTH-1:0] s4_arm;
    logic signed [COORD_WIDTH-1:0] s4_hoff;
    assign s4_z    = s4[SIDE_A-1 -: ZW];
    assign s4_arm  = s4[SIDE_A-ZW-1 -: COORD_WIDTH];
    assign s4_hoff = s4[SIDE_A-ZW-COORD_WIDTH-1 -: COORD_WIDTH];

    // stage after the distance root: d
    logic signed [DDW-1:0] r_d;
    logic [COORD_WIDTH-1:0] r_arm5;
    logic signed [ZW-1:0]  r_z5;
    always_ff @(posedge i_clk) begin
        r_d    <= signed'(DDW'(plane_dist)) - DDW'(s4_hoff);
        r_arm5 <= s4_arm;
        r_z5   <= s4_z;
    end

    // squares
    logic [PW-1:0] r_dd, r_aa;
    logic signed [ZW-1:0] r_z6;
    always_ff @(posedge i_clk) begin
        r_dd <= PW'(r_d * r_d);
        r_aa <= PW'(r_arm5) * PW'(r_arm5);
        r_z6 <= r_z5;
    end

    // difference
    logic [PW-1:0] r_diff;
    logic          r_neg;
    logic signed [ZW-1:0] r_z7;
    always_ff @(posedge i_clk) begin
        r_neg  <= r_aa < r_dd;
        r_diff <= (r_aa < r_dd) ? '0 : r_aa - r_dd;
        r_z7   <= r_z6;
    end

    logic [PW/2-1:0]   rise;
    logic [SIDE_B-1:0] s8;
    dik_isqrt #(.IN_W(PW), .SIDE_W(SIDE_B)) u_rise (
        .i_clk (i_clk),
        .i_rad (r_diff),
        .i_side({r_z7, r_neg}),
        .o_root(rise),
        .o_side(s8)
    );

    // last stage: height with saturation
    logic signed [HSW-1:0] hsum;
    assign hsum = signed'(HSW'(rise)) + HSW'(signed'(s8[SIDE_B-1:1]));
    always_ff @(posedge i_clk) begin
        o_unreach <= s8[0];
        if (s8[0]) begin
            o_height <= '0;
        end else if (hsum > HSW'(4194303)) begin
            o_height <= HW'(4194303);
        end else if (hsum < -HSW'(4194304)) begin
            o_height <= HW'(-4194304);
        end else begin
            o_height <= HW'(hsum);
        end
    end

endmodule

FILE: rtl/delta_inverse_kinematics.sv
// Top level: delta inverse kinematics pipeline with register port.
//  channel  | direction | handshake
//  input    | in        | i_head_* on i_start & !o_busy
//  result   | out       | o_height_*, o_unreachable on o_done
//  config   | in/out    | APB psel/penable/pwrite/pready
// One head position enters per cycle; the delay to each result is set by the two square-root
// pipelines and the multiplier stages, and o_done follows it through the r_vld shift register.
// o_busy is always low. Reset clears the valid pipeline and the tower configuration registers.
// The receiver cannot stall; no beat is dropped or repeated.
module delta_inverse_kinematics #(
    parameter int unsigned COORD_WIDTH = dik_pkg::COORD_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic [dik_pkg::IN_W-1:0]    i_head_x,
    input  logic [dik_pkg::IN_W-1:0]    i_head_y,
    input  logic [dik_pkg::IN_W-1:0]    i_head_z,
    output logic                        o_done,
    output logic [dik_pkg::HEIGHT_W-1:0] o_height_a,
    output logic [dik_pkg::HEIGHT_W-1:0] o_height_b,
    output logic [dik_pkg::HEIGHT_W-1:0] o_height_c,
    output logic [2:0]                  o_unreachable,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [5:0]                  paddr,
    input  logic [63:0]                 pwdata,
    output logic [63:0]                 prdata,
    output logic                        pready
);

    localparam int unsigned IW   = dik_pkg::IN_W;
    localparam int unsigned MW   = (COORD_WIDTH > IW) ? COORD_WIDTH : IW;
    localparam int unsigned DW   = MW + 1;
    localparam int unsigned SQW  = 2 * DW + 1;
    localparam int unsigned RW   = (SQW + 1) / 2;
    localparam int unsigned PW   = 2 * (RW + 1);
    localparam int unsigned LATENCY = 3 + (RW + 1) / 2 + 3 + (PW / 2 + 1) / 2 + 1;
    localparam int unsigned VW   = (3 * COORD_WIDTH > 64) ? 64 - 2 * COORD_WIDTH : COORD_WIDTH;

    logic [63:0] r_pos [dik_pkg::NUM_TOWERS];
    logic [63:0] r_len [dik_pkg::NUM_TOWERS];
    logic        wr_en;
    logic [2:0]  reg_idx;

    assign pready  = 1'b1;
    assign o_busy  = 1'b0;
    assign reg_idx = paddr[5:3];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int t = 0; t < 3; t++) begin
                r_pos[t] <= '0;
                r_len[t] <= '0;
            end
        end else if (wr_en) begin
            case (reg_idx)
                dik_pkg::REG_A_POS: r_pos[0] <= pwdata;
                dik_pkg::REG_A_LEN: r_len[0] <= pwdata;
                dik_pkg::REG_B_POS: r_pos[1] <= pwdata;
                dik_pkg::REG_B_LEN: r_len[1] <= pwdata;
                dik_pkg::REG_C_POS: r_pos[2] <= pwdata;
                dik_pkg::REG_C_LEN: r_len[2] <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            dik_pkg::REG_A_POS: prdata = r_pos[0];
            dik_pkg::REG_A_LEN: prdata = r_len[0];
            dik_pkg::REG_B_POS: prdata = r_pos[1];
            dik_pkg::REG_B_LEN: prdata = r_len[1];
            dik_pkg::REG_C_POS: prdata = r_pos[2];
            dik_pkg::REG_C_LEN: prdata = r_len[2];
            default:            prdata = '0;
        endcase
    end

    logic [LATENCY-1:0] r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LATENCY-2:0], i_start};
        end
    end
    assign o_done = r_vld[LATENCY-1];

    logic [dik_pkg::HEIGHT_W-1:0] height [3];
    logic [2:0] unr;

    for (genvar t = 0; t < 3; t++) begin : g_tower
        logic [VW-1:0] voff_bits;
        assign voff_bits = r_len[t][2*COORD_WIDTH +: VW];
        dik_tower #(.COORD_WIDTH(COORD_WIDTH)) u_tower (
            .i_clk    (i_clk),
            .i_tx     (r_pos[t][COORD_WIDTH-1:0]),
            .i_ty     (r_pos[t][2*COORD_WIDTH-1:COORD_WIDTH]),
            .i_arm    (r_len[t][COORD_WIDTH-1:0]),
            .i_hoff   (r_len[t][2*COORD_WIDTH-1:COORD_WIDTH]),
            .i_voff   (COORD_WIDTH'(signed'(voff_bits))),
            .i_hx     (i_head_x),
            .i_hy     (i_head_y),
            .i_hz     (i_head_z),
            .o_height (height[t]),
            .o_unreach(unr[t])
        );
    end

    assign o_height_a    = height[0];
    assign o_height_b    = height[1];
    assign o_height_c    = height[2];
    assign o_unreachable = unr;

    a_busy_low: assert property (@(posedge i_clk) !o_busy)
        else $error("busy raised");
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> ##(LATENCY-1) o_done)
        else $error("result lost");
    a_unr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_unreachable[0]) |-> (o_height_a == '0))
        else $error("unreachable height not zero");

endmodule

FILE: tb/sv/delta_inverse_kinematics_tb.sv
// Testbench for delta_inverse_kinematics: corner and random head positions against a height predictor.
`timescale 1ns / 100ps

module delta_inverse_kinematics_tb;

    localparam int W = 20;
    localparam int HMAX = 4194303;
    localparam int HMIN = -4194304;
    localparam int N_RANDOM = 600;
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 200;

    typedef struct packed {
        logic [dik_pkg::HEIGHT_W-1:0] ha;
        logic [dik_pkg::HEIGHT_W-1:0] hb;
        logic [dik_pkg::HEIGHT_W-1:0] hc;
        logic [2:0]                   unreach;
    } t_heights;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_start;
    logic                         o_busy;
    logic [dik_pkg::IN_W-1:0]     i_head_x, i_head_y, i_head_z;
    logic                         o_done;
    logic [dik_pkg::HEIGHT_W-1:0] o_height_a, o_height_b, o_height_c;
    logic [2:0]                   o_unreachable;
    logic                         psel, penable, pwrite;
    logic [5:0]                   paddr;
    logic [63:0]                  pwdata, prdata;
    logic                         pready;

    delta_inverse_kinematics u_dut (.*);

    class height_board;
        logic [63:0] tower_pos [3];
        logic [63:0] tower_len [3];
        t_heights    pending [$];
        int          mismatches;

        function longint unsigned root(longint unsigned n);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > n) b >>= 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function void note_head(logic [dik_pkg::IN_W-1:0] x, logic [dik_pkg::IN_W-1:0] y,
                                logic [dik_pkg::IN_W-1:0] z);
            t_heights e;
            logic [dik_pkg::HEIGHT_W-1:0] h [3];
            longint hx, hy, hz, tx, ty, arm, hoff, voff, dx, dy, pdist, d, diff, hv;
            hx = longint'($signed(x));
            hy = longint'($signed(y));
            hz = longint'($signed(z));
            e.unreach = '0;
            for (int t = 0; t < 3; t++) begin
                tx   = longint'($signed(tower_pos[t][W-1:0]));
                ty   = longint'($signed(tower_pos[t][2*W-1:W]));
                arm  = longint'({1'b0, tower_len[t][W-1:0]});
                hoff = longint'($signed(tower_len[t][2*W-1:W]));
                voff = longint'($signed(tower_len[t][3*W-1:2*W]));
                dx = hx - tx;
                dy = hy - ty;
                pdist = longint'(root(dx * dx + dy * dy));
                d = pdist - hoff;
                diff = arm * arm - d * d;
                if (diff < 0) begin
                    e.unreach[t] = 1'b1;
                    h[t] = '0;
                end else begin
                    hv = longint'(root(diff)) + hz + voff;
                    if (hv > HMAX) hv = HMAX;
                    if (hv < HMIN) hv = HMIN;
                    h[t] = hv[dik_pkg::HEIGHT_W-1:0];
                end
            end
            e.ha = h[0];
            e.hb = h[1];
            e.hc = h[2];
            pending.push_back(e);
        endfunction

        function void check_heights(t_heights got);
            t_heights e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %h", got);
                return;
            end
            e = pending.pop_front();
            if (got.ha !== e.ha || got.hb !== e.hb || got.hc !== e.hc
                    || got.unreach !== e.unreach) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp a=%0d b=%0d c=%0d u=%b got a=%0d b=%0d c=%0d u=%b",
                             $signed(e.ha), $signed(e.hb), $signed(e.hc), e.unreach,
                             $signed(got.ha), $signed(got.hb), $signed(got.hc), got.unreach);
            end
        endfunction
    endclass

    height_board board;
    int cycles;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && o_done)
            board.check_heights({o_height_a, o_height_b, o_height_c, o_unreachable});
        if (cycles >= LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx[0]) board.tower_len[idx >> 1] = val;
        else        board.tower_pos[idx >> 1] = val;
    endtask

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        repeat (n) begin
            @(negedge i_clk);
            i_start <= 1'b0;
        end
    endtask

    // drive one beat, leaving start high for a back-to-back beat
    task automatic send_head(logic [dik_pkg::IN_W-1:0] x, logic [dik_pkg::IN_W-1:0] y,
                             logic [dik_pkg::IN_W-1:0] z);
        @(negedge i_clk);
        i_start  <= 1'b1;
        i_head_x <= x;
        i_head_y <= y;
        i_head_z <= z;
        do @(posedge i_clk); while (o_busy);
        board.note_head(x, y, z);
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [19:0] near(int v, int spread);
        return 20'(v + $urandom_range(0, 2 * spread) - spread);
    endfunction

    task automatic tower_setup(int mode);
        logic [63:0] p, l;
        for (int t = 0; t < 3; t++) begin
            case (mode)
                0: begin
                    p = {24'd0, 20'(t * 90000 - 90000), 20'(60000 - t * 50000)};
                    l = {4'd0, 20'(1000 + t), 20'(30000), 20'(250000)};
                end
                1: begin
                    p = {24'd0, 20'h80000, 20'h7FFFF};
                    l = {4'd0, 20'h7FFFF, 20'h80000, 20'hFFFFF};
                end
                2: begin
                    p = {24'd0, 20'h7FFFF, 20'h80000};
                    l = {4'd0, 20'h80000, 20'h7FFFF, 20'd0};
                end
                default: begin
                    p = {$urandom, $urandom};
                    l = {$urandom, $urandom};
                    l[19:0] = 20'($urandom_range(100000, 600000));
                    l[39:20] = 20'($urandom_range(0, 60000));
                end
            endcase
            write_reg(3'(2 * t), p);
            write_reg(3'(2 * t + 1), l);
        end
    endtask

    initial begin
        logic [19:0] e [4];
        board    = new();
        cycles   = 0;
        i_rst_n  = 1'b0;
        i_start  = 1'b0;
        i_head_x = '0;
        i_head_y = '0;
        i_head_z = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        for (int t = 0; t < 3; t++) begin
            board.tower_pos[t] = '0;
            board.tower_len[t] = '0;
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset towers: all arms zero, only the origin is reachable
        send_head(20'd0, 20'd0, 20'd0);
        send_head(20'd0, 20'd0, 20'h7FFFF);
        send_head(20'd1, 20'd0, 20'h80000);
        settle();

        e[0] = 20'h80000; e[1] = 20'h7FFFF; e[2] = 20'd0; e[3] = 20'hFFFFF;
        for (int m = 0; m < 3; m++) begin
            tower_setup(m);
            for (int k = 0; k < 6; k++)
                send_head(e[$urandom_range(0, 3)], e[$urandom_range(0, 3)],
                          e[$urandom_range(0, 3)]);
            // head at tower A's position: planar distance is zero, so d = -hoff
            send_head(board.tower_pos[0][19:0], board.tower_pos[0][39:20], 20'h7FFFF);
            settle();
        end

        for (int ph = 0; ph < 4; ph++) begin
            tower_setup(ph == 0 ? 0 : 3);
            for (int k = 0; k < N_RANDOM / 4; k++) begin
                if ($urandom_range(0, 3) == 0)
                    send_head(20'($urandom), 20'($urandom), 20'($urandom));
                else
                    send_head(near(0, 300000), near(0, 300000), near(0, 200000));
                if ($urandom_range(0, 2) == 0) idle_gap();
            end
            settle();
        end

        if (board.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
